// ----- rtl/core/vxlan_multicast_encap_header_macros.svh -----
// assertion macros for the vxlan multicast encapsulation header block
`ifndef VXLAN_MULTICAST_ENCAP_HEADER_MACROS_SVH
`define VXLAN_MULTICAST_ENCAP_HEADER_MACROS_SVH

`ifndef SYNTH

// condition implies consequence in the same cycle
`define VMEH_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("vmeh assertion failed");

// condition implies consequence in the next cycle
`define VMEH_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("vmeh assertion failed");

`else

`define VMEH_ASSERT_SAME(label, clk, rst, cond, cons)
`define VMEH_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ----- rtl/core/vmeh_pkg.sv -----
// shared types, codes and constants of the vxlan multicast encapsulation header block
package vmeh_pkg;

  // table size default and slot tag width (depth at most 256)
  localparam int VMEH_TABLE_DEPTH = 16;
  localparam int SLOT_W           = 8;

  // largest inner frame length, longer frames are clamped to this
  localparam logic [16:0] MAX_FRAME = 17'd9216;

  // result status codes
  localparam logic [2:0] ST_HEADER    = 3'd0;
  localparam logic [2:0] ST_NOT_MCAST = 3'd1;
  localparam logic [2:0] ST_NO_ENTRY  = 3'd2;
  localparam logic [2:0] ST_INSTALLED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // request types
  localparam logic REQ_INSTALL = 1'b0;
  localparam logic REQ_ENCAP   = 1'b1;

  // configuration register indexes
  localparam logic CFG_NETWORK_ID = 1'b0;
  localparam logic CFG_TTL        = 1'b1;

  // header constants
  localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] IP_VER_TOS   = 16'h4500;
  localparam logic [31:0] IP_FLAGS_DF  = 32'h0000_4000;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
  localparam logic [7:0]  TTL_RESET    = 8'd64;
  localparam logic [16:0] HEADROOM     = 17'd36;
  localparam logic [16:0] UDP_LEN_ADD  = 17'd16;
  localparam logic [15:0] VXLAN_PORT   = 16'd4789;
  localparam logic [31:0] VXLAN_FLAGS  = 32'h0800_0000;
  localparam logic [3:0]  LAST_WORD    = 4'd8;

  // one input beat
  typedef struct packed {
    logic        req_type;
    logic [47:0] entry_mac;
    logic [31:0] group_addr;
    logic [31:0] source_addr;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [13:0] frame_len;
  } req_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] header_word;
    logic [3:0]  word_index;
    logic        last;
  } res_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [47:0]       key;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [31:0]       grp;
    logic [31:0]       src;
    logic              free;
    logic [SLOT_W-1:0] free_slot;
  } tok_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       key;
    logic [31:0]       grp;
    logic [31:0]       src;
  } wr_t;

endpackage

// ----- rtl/core/vmeh_cell.sv -----
// one table cell: holds an entry and passes the search token to its neighbour
module vmeh_cell
  import vmeh_pkg::*;
#(
  parameter int SLOT = 0
) (
  input  logic clk,
  input  logic rst,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  wr_t  wr
);

  logic        valid;
  logic [47:0] key;
  logic [31:0] grp;
  logic [31:0] src;
  logic        match;
  logic        sel;
  tok_t        tok_next;

  assign sel   = wr.en && (wr.slot == SLOT_W'(SLOT));
  assign match = valid && (key == tok_in.key);

  // first match and first free slot along the chain
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit      = 1'b1;
      tok_next.hit_slot = SLOT_W'(SLOT);
      tok_next.grp      = grp;
      tok_next.src      = src;
    end
    if (!tok_in.free && !valid) begin
      tok_next.free      = 1'b1;
      tok_next.free_slot = SLOT_W'(SLOT);
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // entry valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      valid <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (sel) begin
      key <= wr.key;
      grp <= wr.grp;
      src <= wr.src;
    end
  end

endmodule

// ----- rtl/core/vxlan_multicast_encap_header.sv -----
// top level: source mac table as a chain of cells and vxlan/udp/ipv4 header generator
// a request is taken when start is high and busy low; the search token walks one cell per cycle
// install: one result beat, registered after the token has passed every cell
// encapsulation: search through every cell, checksum states S_SUM1 and S_SUM2, then nine beats
//   on consecutive cycles; the next request is taken with the last beat
// results cannot be stalled; synchronous reset empties the table and default entry,
//   network id 0, ttl 64
module vxlan_multicast_encap_header
  import vmeh_pkg::*;
#(
  parameter int TABLE_DEPTH = VMEH_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  output logic        result_valid,
  output res_t        result
);

`include "vxlan_multicast_encap_header_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SUM1 = 3'd2;
  localparam logic [2:0] S_SUM2 = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        accept;
  req_t        req_q;
  tok_t        chain [TABLE_DEPTH+1];
  tok_t        tail;
  wr_t         wr;
  logic [23:0] network_id;
  logic [7:0]  time_to_live;
  logic        default_valid;
  logic [31:0] default_group;
  logic [31:0] default_source;
  logic [31:0] grp_q;
  logic [31:0] src_q;
  logic [31:0] grp_next;
  logic [31:0] src_next;
  logic [19:0] sum;
  logic [19:0] sum_next;
  logic [3:0]  word_cnt;
  logic [3:0]  word_cnt_next;
  logic        result_valid_next;
  res_t        result_next;
  logic        def_wr;
  logic [16:0] len_sat;
  logic [16:0] tot_len;
  logic [16:0] udp_len;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] checksum;
  logic [31:0] word;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign tail   = chain[TABLE_DEPTH];

  // token injected at the head of the chain
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = accept;
    chain[0].key       = (request.req_type == REQ_ENCAP) ? request.src_mac : request.entry_mac;
  end

  // row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vmeh_cell #(
      .SLOT(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[i]),
      .tok_out(chain[i+1]),
      .wr     (wr)
    );
  end

  // frame length clamp and derived lengths
  always_comb begin
    len_sat  = {3'b000, req_q.frame_len};
    if (len_sat > MAX_FRAME) begin
      len_sat = MAX_FRAME;
    end
    tot_len  = len_sat + HEADROOM;
    udp_len  = len_sat + UDP_LEN_ADD;
  end

  // ones-complement fold of the checksum sum
  always_comb begin
    fold1    = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
    fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    checksum = ~fold2[15:0];
  end

  // header word select
  always_comb begin
    case (word_cnt)
      4'd0:    word = {IP_VER_TOS, tot_len[15:0]};
      4'd1:    word = IP_FLAGS_DF;
      4'd2:    word = {time_to_live, IP_PROTO_UDP, checksum};
      4'd3:    word = src_q;
      4'd4:    word = grp_q;
      4'd5:    word = {VXLAN_PORT, VXLAN_PORT};
      4'd6:    word = {udp_len[15:0], 16'h0000};
      4'd7:    word = VXLAN_FLAGS;
      4'd8:    word = {network_id, 8'h00};
      default: word = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next        = state;
    grp_next          = grp_q;
    src_next          = src_q;
    sum_next          = sum;
    word_cnt_next     = word_cnt;
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.last  = 1'b1;
    wr                = '0;
    wr.key            = req_q.entry_mac;
    wr.grp            = req_q.group_addr;
    wr.src            = req_q.source_addr;
    def_wr            = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_next = S_IDLE;
          if (req_q.req_type == REQ_INSTALL) begin
            result_valid_next = 1'b1;
            result_next.status = ST_INSTALLED;
            if (req_q.entry_mac == MAC_ALL_ONES) begin
              def_wr = 1'b1;
            end else if (tail.hit) begin
              wr.en   = 1'b1;
              wr.slot = tail.hit_slot;
            end else if (tail.free) begin
              wr.en   = 1'b1;
              wr.slot = tail.free_slot;
            end else begin
              result_next.status = ST_FULL;
            end
          end else if (!req_q.dest_mac[40]) begin
            result_valid_next  = 1'b1;
            result_next.status = ST_NOT_MCAST;
          end else if (tail.hit) begin
            grp_next   = tail.grp;
            src_next   = tail.src;
            state_next = S_SUM1;
          end else if (default_valid) begin
            grp_next   = default_group;
            src_next   = default_source;
            state_next = S_SUM1;
          end else begin
            result_valid_next  = 1'b1;
            result_next.status = ST_NO_ENTRY;
          end
        end
      end
      S_SUM1: begin
        sum_next   = 20'({4'd0, IP_VER_TOS}) + 20'({4'd0, tot_len[15:0]}) +
                     20'({4'd0, IP_FLAGS_DF[15:0]}) + 20'({4'd0, time_to_live, IP_PROTO_UDP});
        state_next = S_SUM2;
      end
      S_SUM2: begin
        sum_next      = sum + 20'({4'd0, src_q[31:16]}) + 20'({4'd0, src_q[15:0]}) +
                        20'({4'd0, grp_q[31:16]}) + 20'({4'd0, grp_q[15:0]});
        word_cnt_next = '0;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        result_valid_next       = 1'b1;
        result_next.status      = ST_HEADER;
        result_next.header_word = word;
        result_next.word_index  = word_cnt;
        result_next.last        = (word_cnt == LAST_WORD);
        word_cnt_next           = word_cnt + 4'd1;
        if (word_cnt == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    grp_q    <= grp_next;
    src_q    <= src_next;
    sum      <= sum_next;
    word_cnt <= word_cnt_next;
    result   <= result_next;
  end

  // default entry
  always_ff @(posedge clk) begin
    if (rst) begin
      default_valid  <= 1'b0;
      default_group  <= '0;
      default_source <= '0;
    end else if (def_wr) begin
      default_valid  <= 1'b1;
      default_group  <= req_q.group_addr;
      default_source <= req_q.source_addr;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      network_id   <= '0;
      time_to_live <= TTL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NETWORK_ID: network_id   <= cfg_data;
        CFG_TTL:        time_to_live <= cfg_data[7:0];
        default:        network_id   <= network_id;
      endcase
    end
  end

  // checks
  `VMEH_ASSERT_SAME(a_single_is_last, clk, rst, result_valid && (result.status != ST_HEADER), result.last)
  `VMEH_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `VMEH_ASSERT_NEXT(a_words_run_on, clk, rst, result_valid && !result.last, result_valid)
  `VMEH_ASSERT_SAME(a_tail_in_scan, clk, rst, tail.valid, state == S_SCAN)

endmodule
